### sv/rvx_pkg.sv
// Shared types, opcodes and helper functions of the RV32 instruction executor.
package rvx_pkg;

    localparam int DMEM_BYTES_DEF = 4096;
    localparam int RF_DEPTH       = 32;
    localparam int QDEPTH         = 2;
    localparam int QAW            = $clog2(QDEPTH);

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_FENCE  = 7'h0f;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MULD = 7'h01;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LUI,
        OP_AUIPC,
        OP_JAL,
        OP_JALR,
        OP_BRANCH,
        OP_LOAD,
        OP_STORE,
        OP_ALU,
        OP_MUL,
        OP_DIV,
        OP_DIVU,
        OP_REMU
    } op_t;

    typedef enum logic [3:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_SLL,
        ALU_SLT,
        ALU_SLTU,
        ALU_XOR,
        ALU_SRL,
        ALU_SRA,
        ALU_OR,
        ALU_AND
    } alu_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_ADDR,
        ST_MOD,
        ST_MEM,
        ST_MEMW,
        ST_RESP
    } st_t;

    typedef struct packed {
        op_t         op;
        alu_t        alu;
        logic        use_imm;
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic        ill;
    } item_t;

    function automatic logic [31:0] alu_calc(input logic [31:0] a, input logic [31:0] b,
                                             input alu_t op);
        logic [31:0] r;
        r = '0;
        case (op)
            ALU_ADD:  r = a + b;
            ALU_SUB:  r = a - b;
            ALU_SLL:  r = a << b[4:0];
            ALU_SLT:  r = {31'b0, $signed(a) < $signed(b)};
            ALU_SLTU: r = {31'b0, a < b};
            ALU_XOR:  r = a ^ b;
            ALU_SRL:  r = a >> b[4:0];
            ALU_SRA:  r = $unsigned($signed(a) >>> b[4:0]);
            ALU_OR:   r = a | b;
            ALU_AND:  r = a & b;
            default:  r = '0;
        endcase
        return r;
    endfunction

endpackage

### sv/rv32_instruction_executor_unit.sv
// Top level of the RV32 instruction executor.
//
// Usage:
//   Instruction channel: drive instr_word and raise push; the beat is taken at
//   a clock edge with push high and full low. A two-entry queue decouples the
//   decoder from the execute sequencer.
//   Result channel: while empty is low the oldest result sits on the result
//   ports; it is taken at an edge with pop high. One result per instruction.
//   Start PC: a write beat (start_pc_valid with start_pc_ready) loads the PC.
//   Sequencing: ALU, jump, branch, LUI/AUIPC and MUL go from the queue head
//   through the IDLE, EXEC and RESP states to the result register; DIV, DIVU
//   and REMU also wait in the DIV state on the bit-serial divider; each byte
//   of a load or store passes the ADDR and MEM states (loads also MEMW) on the
//   one-port byte memory, plus a MOD pass once per access when DATA_MEM_BYTES
//   is not a power of two (address remainder by compare and subtract; later
//   bytes step the index by one). The back end runs one instruction at a time.
//   Reset: PC and registers clear to zero; data memory holds no defined value.
//   A stalled receiver holds the result; the back end waits before its next
//   register write and the queue fills until full rises.
module rv32_instruction_executor_unit
    import rvx_pkg::*;
#(
    parameter int DATA_MEM_BYTES = DMEM_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] instr_word,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] next_pc,
    output logic        reg_written,
    output logic [4:0]  dest_index,
    output logic [31:0] dest_value,
    output logic        mem_written,
    output logic [31:0] mem_address,
    output logic        illegal,
    input  logic        start_pc_valid,
    output logic        start_pc_ready,
    input  logic [31:0] start_pc
);

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    assign start_pc_ready = 1'b1;

    rvx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .instr_word (instr_word),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item)
    );

    rvx_back #(.DMEM_BYTES(DATA_MEM_BYTES)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .cfg_we      (start_pc_valid && start_pc_ready),
        .cfg_data    (start_pc),
        .empty       (empty),
        .pop         (pop),
        .next_pc     (next_pc),
        .reg_written (reg_written),
        .dest_index  (dest_index),
        .dest_value  (dest_value),
        .mem_written (mem_written),
        .mem_address (mem_address),
        .illegal     (illegal)
    );

endmodule

### sv/rvx_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rvx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/rvx_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
module rvx_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [31:0] quot,
    output logic [31:0] rem
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [32:0] r_sh;
    logic [32:0] diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        r_sh      = {r_reg, q_reg[31]};
        diff      = r_sh - {1'b0, d_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd31;
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                r_next = diff[31:0];
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = r_sh[31:0];
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

### sv/rvx_front.sv
// Front end: instruction beat intake, decode and the decoupling queue.
module rvx_front
    import rvx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] instr_word,
    output logic        q_valid,
    input  logic        q_ready,
    output item_t       q_item
);

    item_t       dec;
    item_t       q_mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;
    logic        wr_en;
    logic        rd_en;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;

    assign opc   = instr_word[6:0];
    assign f3    = instr_word[14:12];
    assign f7    = instr_word[31:25];
    assign imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
    assign imm_s = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
    assign imm_b = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                    instr_word[30:25], instr_word[11:8], 1'b0};
    assign imm_j = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                    instr_word[20], instr_word[30:21], 1'b0};
    assign imm_u = {instr_word[31:12], 12'b0};

    always_comb
    begin
        dec         = '0;
        dec.op      = OP_NOP;
        dec.alu     = ALU_ADD;
        dec.f3      = f3;
        dec.rd      = instr_word[11:7];
        dec.rs1     = instr_word[19:15];
        dec.rs2     = instr_word[24:20];
        case (opc)
            OPC_LUI:
            begin
                dec.op  = OP_LUI;
                dec.imm = imm_u;
            end
            OPC_AUIPC:
            begin
                dec.op  = OP_AUIPC;
                dec.imm = imm_u;
            end
            OPC_JAL:
            begin
                dec.op  = OP_JAL;
                dec.imm = imm_j;
            end
            OPC_JALR:
            begin
                dec.op  = OP_JALR;
                dec.imm = imm_i;
                dec.ill = (f3 != 3'd0);
            end
            OPC_BRANCH:
            begin
                dec.op  = OP_BRANCH;
                dec.imm = imm_b;
                dec.ill = (f3 == 3'd2) || (f3 == 3'd3);
            end
            OPC_LOAD:
            begin
                dec.op  = OP_LOAD;
                dec.imm = imm_i;
                dec.ill = (f3 == 3'd3) || (f3 == 3'd6) || (f3 == 3'd7);
            end
            OPC_STORE:
            begin
                dec.op  = OP_STORE;
                dec.imm = imm_s;
                dec.ill = (f3 > 3'd2);
            end
            OPC_OPIMM:
            begin
                dec.op      = OP_ALU;
                dec.use_imm = 1'b1;
                dec.imm     = imm_i;
                case (f3)
                    F3_ADD:  dec.alu = ALU_ADD;
                    F3_SLT:  dec.alu = ALU_SLT;
                    F3_SLTU: dec.alu = ALU_SLTU;
                    F3_XOR:  dec.alu = ALU_XOR;
                    F3_OR:   dec.alu = ALU_OR;
                    F3_AND:  dec.alu = ALU_AND;
                    F3_SLL:
                    begin
                        dec.alu = ALU_SLL;
                        dec.ill = (f7 != F7_BASE);
                    end
                    default:
                    begin
                        if (f7 == F7_BASE)
                        begin
                            dec.alu = ALU_SRL;
                        end
                        else if (f7 == F7_ALT)
                        begin
                            dec.alu = ALU_SRA;
                        end
                        else
                        begin
                            dec.ill = 1'b1;
                        end
                    end
                endcase
            end
            OPC_OP:
            begin
                dec.op = OP_ALU;
                if (f7 == F7_BASE)
                begin
                    case (f3)
                        F3_ADD:  dec.alu = ALU_ADD;
                        F3_SLL:  dec.alu = ALU_SLL;
                        F3_SLT:  dec.alu = ALU_SLT;
                        F3_SLTU: dec.alu = ALU_SLTU;
                        F3_XOR:  dec.alu = ALU_XOR;
                        F3_SR:   dec.alu = ALU_SRL;
                        F3_OR:   dec.alu = ALU_OR;
                        default: dec.alu = ALU_AND;
                    endcase
                end
                else if (f7 == F7_ALT && f3 == F3_ADD)
                begin
                    dec.alu = ALU_SUB;
                end
                else if (f7 == F7_ALT && f3 == F3_SR)
                begin
                    dec.alu = ALU_SRA;
                end
                else if (f7 == F7_MULD && f3 == 3'd0)
                begin
                    dec.op = OP_MUL;
                end
                else if (f7 == F7_MULD && f3 == 3'd4)
                begin
                    dec.op = OP_DIV;
                end
                else if (f7 == F7_MULD && f3 == 3'd5)
                begin
                    dec.op = OP_DIVU;
                end
                else if (f7 == F7_MULD && f3 == 3'd7)
                begin
                    dec.op = OP_REMU;
                end
                else
                begin
                    dec.ill = 1'b1;
                end
            end
            OPC_FENCE:
            begin
                dec.ill = (f3 != 3'd0);
            end
            default:
            begin
                dec.ill = 1'b1;
            end
        endcase
        if (dec.ill)
        begin
            dec.op = OP_NOP;
        end
    end

    assign full    = (count_reg == (QAW+1)'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = q_mem[rd_ptr_reg];
    assign wr_en   = push && !full;
    assign rd_en   = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg + (QAW+1)'(wr_en) - (QAW+1)'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem[wr_ptr_reg] <= dec;
        end
    end

endmodule

### sv/rvx_back.sv
// Back end: register file, execute sequencer, data memory and result register.
module rvx_back
    import rvx_pkg::*;
#(
    parameter int DMEM_BYTES = DMEM_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] next_pc,
    output logic        reg_written,
    output logic [4:0]  dest_index,
    output logic [31:0] dest_value,
    output logic        mem_written,
    output logic [31:0] mem_address,
    output logic        illegal
);

    localparam int  DAW     = $clog2(DMEM_BYTES);
    localparam int  RAW     = $clog2(RF_DEPTH);
    localparam bit  DM_POW2 = ((DMEM_BYTES & (DMEM_BYTES - 1)) == 0);
    localparam int  MOD_TOP = 33 - DAW;
    localparam logic [DAW-1:0] IDX_LAST = DAW'(DMEM_BYTES - 1);

    st_t         state_reg, state_next;
    item_t       it_reg, it_next;
    logic [31:0] pc_reg, pc_next;
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] res_reg, res_next;
    logic [31:0] npc_reg, npc_next;
    logic [31:0] addr_reg, addr_next;
    logic [31:0] ld_reg, ld_next;
    logic        wr_reg, wr_next;
    logic        mw_reg, mw_next;
    logic        ill_reg, ill_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [DAW-1:0] idx_reg, idx_next;
    logic [31:0] mr_reg, mr_next;
    logic [4:0]  mk_reg, mk_next;
    logic [RF_DEPTH-1:0] rf_vld_reg, rf_vld_next;
    logic        rf_vld1_reg, rf_vld1_next;
    logic        rf_vld2_reg, rf_vld2_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_npc_reg;
    logic        out_wr_reg;
    logic [4:0]  out_rd_reg;
    logic [31:0] out_res_reg;
    logic        out_mw_reg;
    logic [31:0] out_addr_reg;
    logic        out_ill_reg;

    logic [RAW-1:0] rf_ra1, rf_ra2;
    logic [31:0] rf_rd1, rf_rd2;
    logic        commit;
    logic [31:0] a_cur, b_cur, pc4, eff, baddr, ld_full;
    logic [63:0] prod;
    logic [39:0] msh, mdiff;
    logic [31:0] mr_fin;
    logic        took;
    logic        last;
    logic [1:0]  nlast;
    logic        q_fire;

    logic        div_start, div_busy, div_done;
    logic [31:0] div_a, div_b, div_q, div_r;

    logic        dm_we;
    logic [7:0]  dm_wdata, dm_rdata;

    assign rf_ra1 = (state_reg == ST_IDLE) ? q_item.rs1 : it_reg.rs1;
    assign rf_ra2 = (state_reg == ST_IDLE) ? q_item.rs2 : it_reg.rs2;

    rvx_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf1 (
        .clk   (clk),
        .we    (commit),
        .waddr (it_reg.rd),
        .wdata (res_reg),
        .raddr (rf_ra1),
        .rdata (rf_rd1)
    );

    rvx_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf2 (
        .clk   (clk),
        .we    (commit),
        .waddr (it_reg.rd),
        .wdata (res_reg),
        .raddr (rf_ra2),
        .rdata (rf_rd2)
    );

    rvx_ram #(.WIDTH(8), .DEPTH(DMEM_BYTES)) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (idx_reg),
        .wdata (dm_wdata),
        .raddr (idx_reg),
        .rdata (dm_rdata)
    );

    rvx_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    assign a_cur    = rf_vld1_reg ? rf_rd1 : '0;
    assign b_cur    = rf_vld2_reg ? rf_rd2 : '0;
    assign pc4      = pc_reg + 32'd4;
    assign eff      = a_cur + it_reg.imm;
    assign prod     = a_cur * b_cur;
    assign baddr    = addr_reg + {30'b0, cnt_reg};
    assign nlast    = (it_reg.f3[1:0] == 2'd0) ? 2'd0 : (it_reg.f3[1:0] == 2'd1) ? 2'd1 : 2'd3;
    assign last     = (cnt_reg == nlast);
    assign ld_full  = ld_reg | ({24'b0, dm_rdata} << {cnt_reg, 3'b000});
    assign dm_wdata = 8'(b_reg >> {cnt_reg, 3'b000});
    assign dm_we    = (state_reg == ST_MEM) && (it_reg.op == OP_STORE);
    assign q_ready  = (state_reg == ST_IDLE);
    assign q_fire   = q_valid && q_ready;
    assign commit   = (state_reg == ST_RESP) && (!out_valid_reg || pop) && wr_reg;
    assign msh      = 40'(DMEM_BYTES) << mk_reg;
    assign mdiff    = {8'b0, mr_reg} - msh;
    assign mr_fin   = mdiff[39] ? mr_reg : mdiff[31:0];

    always_comb
    begin
        case (it_reg.f3)
            F3_BEQ:  took = (a_cur == b_cur);
            F3_BNE:  took = (a_cur != b_cur);
            F3_BLT:  took = ($signed(a_cur) < $signed(b_cur));
            F3_BGE:  took = ($signed(a_cur) >= $signed(b_cur));
            F3_BLTU: took = (a_cur < b_cur);
            F3_BGEU: took = (a_cur >= b_cur);
            default: took = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        it_next        = it_reg;
        pc_next        = pc_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        res_next       = res_reg;
        npc_next       = npc_reg;
        addr_next      = addr_reg;
        ld_next        = ld_reg;
        wr_next        = wr_reg;
        mw_next        = mw_reg;
        ill_next       = ill_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        mr_next        = mr_reg;
        mk_next        = mk_reg;
        rf_vld_next    = rf_vld_reg;
        rf_vld1_next   = rf_vld1_reg;
        rf_vld2_next   = rf_vld2_reg;
        out_valid_next = out_valid_reg && !pop;
        div_start      = 1'b0;
        div_a          = a_cur;
        div_b          = b_cur;

        if (cfg_we)
        begin
            pc_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    it_next      = q_item;
                    rf_vld1_next = rf_vld_reg[q_item.rs1];
                    rf_vld2_next = rf_vld_reg[q_item.rs2];
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                a_next    = a_cur;
                b_next    = b_cur;
                res_next  = '0;
                npc_next  = pc4;
                addr_next = '0;
                ld_next   = '0;
                cnt_next  = '0;
                wr_next   = 1'b0;
                mw_next   = 1'b0;
                ill_next  = it_reg.ill;
                state_next = ST_RESP;
                case (it_reg.op)
                    OP_LUI:
                    begin
                        res_next = it_reg.imm;
                        wr_next  = 1'b1;
                    end
                    OP_AUIPC:
                    begin
                        res_next = pc_reg + it_reg.imm;
                        wr_next  = 1'b1;
                    end
                    OP_JAL:
                    begin
                        res_next = pc4;
                        wr_next  = 1'b1;
                        npc_next = pc_reg + it_reg.imm;
                    end
                    OP_JALR:
                    begin
                        res_next = pc4;
                        wr_next  = 1'b1;
                        npc_next = eff & 32'hffff_fffe;
                    end
                    OP_BRANCH:
                    begin
                        if (took)
                        begin
                            npc_next = pc_reg + it_reg.imm;
                        end
                    end
                    OP_LOAD:
                    begin
                        addr_next  = eff;
                        wr_next    = 1'b1;
                        state_next = ST_ADDR;
                    end
                    OP_STORE:
                    begin
                        addr_next  = a_cur + it_reg.imm;
                        mw_next    = 1'b1;
                        state_next = ST_ADDR;
                    end
                    OP_ALU:
                    begin
                        res_next = alu_calc(a_cur, it_reg.use_imm ? it_reg.imm : b_cur,
                                            it_reg.alu);
                        wr_next  = 1'b1;
                    end
                    OP_MUL:
                    begin
                        res_next = prod[31:0];
                        wr_next  = 1'b1;
                    end
                    OP_DIV:
                    begin
                        div_start  = 1'b1;
                        div_a      = a_cur[31] ? (32'd0 - a_cur) : a_cur;
                        div_b      = b_cur[31] ? (32'd0 - b_cur) : b_cur;
                        wr_next    = 1'b1;
                        state_next = ST_DIV;
                    end
                    OP_DIVU, OP_REMU:
                    begin
                        div_start  = 1'b1;
                        div_a      = a_cur;
                        div_b      = b_cur;
                        wr_next    = 1'b1;
                        state_next = ST_DIV;
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
                if (it_reg.rd == 5'd0)
                begin
                    wr_next = 1'b0;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    case (it_reg.op)
                        OP_DIV:
                        begin
                            if (b_reg == 32'd0)
                            begin
                                res_next = 32'hffff_ffff;
                            end
                            else if (a_reg[31] ^ b_reg[31])
                            begin
                                res_next = 32'd0 - div_q;
                            end
                            else
                            begin
                                res_next = div_q;
                            end
                        end
                        OP_DIVU: res_next = div_q;
                        default: res_next = div_r;
                    endcase
                    state_next = ST_RESP;
                end
            end
            ST_ADDR:
            begin
                if (DM_POW2)
                begin
                    idx_next   = baddr[DAW-1:0];
                    state_next = ST_MEM;
                end
                else if (cnt_reg != 2'd0)
                begin
                    // advance one byte, wrapping at the memory size and at 2^32
                    if ((baddr == 32'd0) || (idx_reg == IDX_LAST))
                    begin
                        idx_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + DAW'(1);
                    end
                    state_next = ST_MEM;
                end
                else
                begin
                    mr_next    = baddr;
                    mk_next    = 5'(MOD_TOP);
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                mr_next = mr_fin;
                mk_next = mk_reg - 5'd1;
                if (mk_reg == 5'd0)
                begin
                    idx_next   = mr_fin[DAW-1:0];
                    state_next = ST_MEM;
                end
            end
            ST_MEM:
            begin
                if (it_reg.op == OP_STORE)
                begin
                    if (last)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 2'd1;
                        state_next = ST_ADDR;
                    end
                end
                else
                begin
                    state_next = ST_MEMW;
                end
            end
            ST_MEMW:
            begin
                ld_next = ld_full;
                if (last)
                begin
                    case (it_reg.f3)
                        F3_LB:   res_next = {{24{ld_full[7]}}, ld_full[7:0]};
                        F3_LH:   res_next = {{16{ld_full[15]}}, ld_full[15:0]};
                        F3_LBU:  res_next = {24'b0, ld_full[7:0]};
                        F3_LHU:  res_next = {16'b0, ld_full[15:0]};
                        default: res_next = ld_full;
                    endcase
                    state_next = ST_RESP;
                end
                else
                begin
                    cnt_next   = cnt_reg + 2'd1;
                    state_next = ST_ADDR;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    pc_next        = npc_reg;
                    if (wr_reg)
                    begin
                        rf_vld_next[it_reg.rd] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            cnt_reg       <= '0;
            rf_vld_reg    <= '0;
            rf_vld1_reg   <= 1'b0;
            rf_vld2_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            rf_vld_reg    <= rf_vld_next;
            rf_vld1_reg   <= rf_vld1_next;
            rf_vld2_reg   <= rf_vld2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg   <= it_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        res_reg  <= res_next;
        npc_reg  <= npc_next;
        addr_reg <= addr_next;
        ld_reg   <= ld_next;
        wr_reg   <= wr_next;
        mw_reg   <= mw_next;
        ill_reg  <= ill_next;
        idx_reg  <= idx_next;
        mr_reg   <= mr_next;
        mk_reg   <= mk_next;
        if ((state_reg == ST_RESP) && (!out_valid_reg || pop))
        begin
            out_npc_reg  <= npc_reg;
            out_wr_reg   <= wr_reg;
            out_rd_reg   <= wr_reg ? it_reg.rd : 5'd0;
            out_res_reg  <= wr_reg ? res_reg : 32'd0;
            out_mw_reg   <= mw_reg;
            out_addr_reg <= addr_reg;
            out_ill_reg  <= ill_reg;
        end
    end

    assign empty       = !out_valid_reg;
    assign next_pc     = out_npc_reg;
    assign reg_written = out_wr_reg;
    assign dest_index  = out_rd_reg;
    assign dest_value  = out_res_reg;
    assign mem_written = out_mw_reg;
    assign mem_address = out_addr_reg;
    assign illegal     = out_ill_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) !rf_vld_reg[0])
        else $error("x0 marked as written");
    assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_busy)
        else $error("divider restarted while busy");
    assert property (@(posedge clk) disable iff (!rst_n) q_fire |=> (state_reg == ST_EXEC))
        else $error("taken item did not reach execute");
    assert property (@(posedge clk) disable iff (!rst_n) commit |=> out_valid_reg)
        else $error("register write without result beat");
`endif

endmodule
